/* rtl/budgeted_top_score_selector_unit_defines.svh */
// Assertion macros for the selector RTL.
`ifndef BUDGETED_TOP_SCORE_SELECTOR_UNIT_DEFINES_SVH
`define BUDGETED_TOP_SCORE_SELECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst is high.
`define BTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, off while rst is high.
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/bts_pkg.sv */
package bts_pkg;

  // Field widths
  localparam int SCORE_W    = 16;
  localparam int WORDS_W    = 10;
  localparam int TOTAL_W    = 16;
  localparam int BUDGET_W   = 16;
  localparam int MODE_W     = 2;
  localparam int SENT_IDX_W = 6;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 8;
  localparam int PCT_W      = 7;
  localparam int PROD_W     = TOTAL_W + PCT_W;

  localparam int MAX_SENTENCES_DEF = 64;

  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET      = 1'b1;

  // Selection modes
  localparam logic [MODE_W-1:0] MODE_PERCENT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LINES   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WORDS   = 2'd2;

  // Best-so-far candidate passed along the cell chain
  typedef struct packed {
    logic                  valid;
    logic [SCORE_W-1:0]    score;
    logic [WORDS_W-1:0]    words;
    logic [SENT_IDX_W-1:0] idx;
  } cand_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic                  load;
    logic [SENT_IDX_W-1:0] load_idx;
    logic [SCORE_W-1:0]    load_score;
    logic [WORDS_W-1:0]    load_words;
    logic                  mark;
    logic [SENT_IDX_W-1:0] mark_idx;
    logic                  clear;
    logic                  rep_load;
    logic                  rep_shift;
  } cell_ctl_t;

endpackage

/* rtl/bts_cell.sv */
module bts_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  bts_pkg::cell_ctl_t ctl,
  input  bts_pkg::cand_t    cand_in,
  output bts_pkg::cand_t    cand_out,
  input  logic              rep_in,
  output logic              rep_out
);
  import bts_pkg::*;

  localparam logic [SENT_IDX_W-1:0] MY_IDX = SENT_IDX_W'(CELL_IDX);

  logic               loaded;
  logic               picked;
  logic [SCORE_W-1:0] score;
  logic [WORDS_W-1:0] words;
  logic               eligible;
  cand_t              cand_next;

  // A held, unpicked sentence replaces the incoming best when that is empty or on a strictly
  // higher score, so the earliest sentence keeps a tie.
  always_comb begin
    eligible  = loaded && !picked;
    cand_next = cand_in;
    if (eligible && (!cand_in.valid || score > cand_in.score)) begin
      cand_next.valid = 1'b1;
      cand_next.score = score;
      cand_next.words = words;
      cand_next.idx   = MY_IDX;
    end
  end

  // Flags and candidate register
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded   <= 1'b0;
      picked   <= 1'b0;
      cand_out <= '0;
    end else begin
      cand_out <= cand_next;
      if (ctl.clear) begin
        loaded <= 1'b0;
        picked <= 1'b0;
      end else begin
        if (ctl.load && ctl.load_idx == MY_IDX) loaded <= 1'b1;
        if (ctl.mark && ctl.mark_idx == MY_IDX) picked <= 1'b1;
      end
    end
  end

  // Sentence payload and report shift stage
  always_ff @(posedge clk) begin
    if (ctl.load && ctl.load_idx == MY_IDX) begin
      score <= ctl.load_score;
      words <= ctl.load_words;
    end
    if (ctl.rep_load) begin
      rep_out <= picked;
    end else if (ctl.rep_shift) begin
      rep_out <= rep_in;
    end
  end

endmodule

/* rtl/bts_ctrl.sv */
module bts_ctrl #(
  parameter int MAX_SENTENCES = bts_pkg::MAX_SENTENCES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bts_pkg::BUDGET_W-1:0]   cfg_wdata,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bts_pkg::SCORE_W-1:0]    in_score,
  input  logic [bts_pkg::WORDS_W-1:0]    in_words,
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bts_pkg::SENT_IDX_W-1:0] out_idx,
  output logic                           out_chosen,
  output logic                           m_tlast,
  input  bts_pkg::cand_t                 winner,
  input  logic                           rep_head,
  output bts_pkg::cell_ctl_t             ctl
);
  import bts_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_APPLY = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

  localparam logic [CNT_W-1:0] N_CNT    = CNT_W'(MAX_SENTENCES);
  localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(MAX_SENTENCES - 1);

  state_t              state;
  state_t              state_next;
  logic [MODE_W-1:0]   select_mode;
  logic [BUDGET_W-1:0] budget;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    picks;
  logic [CNT_W-1:0]    scan_cnt;
  logic [CNT_W-1:0]    out_k;
  logic [TOTAL_W-1:0]  total_words;
  logic [TOTAL_W-1:0]  picked_words;

  logic                in_acc;
  logic                out_adv;
  logic                go_on;
  logic [PCT_W-1:0]    pct;
  logic [PROD_W-1:0]   lhs;
  logic [PROD_W-1:0]   rhs;
  logic [BUDGET_W-1:0] line_limit;
  logic                out_last;

  assign s_tready = (state == ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_adv  = (state == ST_DRAIN) && (!m_tvalid || m_tready);
  assign out_last = (out_k + CNT_W'(1)) == count;

  // Stop rule for the current mode
  always_comb begin
    pct        = (budget > BUDGET_W'(PCT_FULL)) ? PCT_FULL : budget[PCT_W-1:0];
    lhs        = PROD_W'(picked_words) * PROD_W'(PCT_FULL);
    rhs        = PROD_W'(pct) * PROD_W'(total_words);
    line_limit = (budget < BUDGET_W'(count)) ? budget : BUDGET_W'(count);
    unique case (select_mode)
      MODE_PERCENT: go_on = lhs < rhs;
      MODE_LINES:   go_on = BUDGET_W'(picks) < line_limit;
      MODE_WORDS:   go_on = (picked_words < total_words) && (picked_words <= budget);
      default:      go_on = 1'b0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc && s_tlast) state_next = ST_CHECK;
      ST_CHECK: state_next = (go_on && picks != count) ? ST_SCAN : ST_DRAIN;
      ST_SCAN:  if (scan_cnt == SCAN_END) state_next = ST_APPLY;
      ST_APPLY: state_next = ST_CHECK;
      ST_DRAIN: if (out_adv && out_last) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Cell control broadcast
  always_comb begin
    ctl            = '0;
    ctl.load       = in_acc && (count < N_CNT);
    ctl.load_idx   = count[SENT_IDX_W-1:0];
    ctl.load_score = in_score;
    ctl.load_words = in_words;
    ctl.mark       = (state == ST_APPLY) && winner.valid;
    ctl.mark_idx   = winner.idx;
    ctl.clear      = out_adv && out_last;
    ctl.rep_load   = (state == ST_CHECK) && !(go_on && picks != count);
    ctl.rep_shift  = out_adv;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      select_mode  <= MODE_PERCENT;
      budget       <= '0;
      count        <= '0;
      picks        <= '0;
      scan_cnt     <= '0;
      out_k        <= '0;
      total_words  <= '0;
      picked_words <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SELECT_MODE: select_mode <= cfg_wdata[MODE_W-1:0];
          REG_BUDGET:      budget      <= cfg_wdata;
          default:         ;
        endcase
      end
      if (ctl.load) begin
        count       <= count + CNT_W'(1);
        total_words <= total_words + TOTAL_W'(in_words);
      end
      if (state == ST_CHECK) scan_cnt <= '0;
      else if (state == ST_SCAN) scan_cnt <= scan_cnt + CNT_W'(1);
      if (ctl.mark) begin
        picks        <= picks + CNT_W'(1);
        picked_words <= picked_words + TOTAL_W'(winner.words);
      end
      if (out_adv) begin
        m_tvalid <= 1'b1;
        out_k    <= out_k + CNT_W'(1);
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      // end of document: clear running totals
      if (ctl.clear) begin
        count        <= '0;
        picks        <= '0;
        out_k        <= '0;
        total_words  <= '0;
        picked_words <= '0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_idx    <= out_k[SENT_IDX_W-1:0];
      out_chosen <= rep_head;
      m_tlast    <= out_last;
    end
  end

endmodule

/* rtl/budgeted_top_score_selector_unit.sv */
// Channel   Dir  Payload (low bit up)                    Marker
// cfg       in   cfg_index, cfg_wdata (mode / budget)    cfg_we
// s (item)  in   tdata: score[15:0], word_count[25:16]   tlast = last_sentence
// m (res)   out  tdata: sentence_index[5:0], chosen[6]   tlast = last_result
//
// Each accepted item is stored in the next free cell. The last item starts selection:
// every pick is one pass of a best-candidate token along the row of MAX_SENTENCES
// cells. Results shift out of the cells one per cycle while m_tready allows; the
// input is not ready from the last item until the final result is registered.
// rst is synchronous and clears counts, picked flags and valid bits at once.
`include "budgeted_top_score_selector_unit_defines.svh"

module budgeted_top_score_selector_unit #(
  parameter int MAX_SENTENCES = bts_pkg::MAX_SENTENCES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [bts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bts_pkg::BUDGET_W-1:0]  cfg_wdata,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bts_pkg::S_TDATA_W-1:0] s_tdata,   // score, word_count
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [bts_pkg::M_TDATA_W-1:0] m_tdata,   // sentence_index, chosen
  output logic                          m_tlast
);
  import bts_pkg::*;

  cand_t                 cand [MAX_SENTENCES+1];
  logic                  rep  [MAX_SENTENCES+1];
  cell_ctl_t             ctl;
  logic [SENT_IDX_W-1:0] out_idx;
  logic                  out_chosen;

  assign cand[0]              = '0;
  assign rep[MAX_SENTENCES]   = 1'b0;
  assign m_tdata              = {{(M_TDATA_W-SENT_IDX_W-1){1'b0}}, out_chosen, out_idx};

  // Sequencer
  bts_ctrl #(
    .MAX_SENTENCES(MAX_SENTENCES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .in_score   (s_tdata[SCORE_W-1:0]),
    .in_words   (s_tdata[SCORE_W+WORDS_W-1:SCORE_W]),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .out_idx    (out_idx),
    .out_chosen (out_chosen),
    .m_tlast    (m_tlast),
    .winner     (cand[MAX_SENTENCES]),
    .rep_head   (rep[0]),
    .ctl        (ctl)
  );

  // Row of sentence cells: candidate flows up, report flows down
  for (genvar i = 0; i < MAX_SENTENCES; i++) begin : g_cell
    bts_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl),
      .cand_in  (cand[i]),
      .cand_out (cand[i+1]),
      .rep_in   (rep[i+1]),
      .rep_out  (rep[i])
    );
  end

  // Checks
  `BTS_ASSERT_NOW(a_mark_has_winner, ctl.mark, cand[MAX_SENTENCES].valid, "pick without winner")
  `BTS_ASSERT_NEXT(a_clear_ends_doc, ctl.clear, m_tvalid && m_tlast, "clear without final result")
  `BTS_ASSERT_NEXT(a_report_blocks_in, ctl.rep_load, !s_tready, "input open during results")

endmodule
